>>> sv/npc_pkg.sv
// Shared types, widths and codes for the nearest point classifier.
package npc_pkg;

  localparam int GRID_SIZE_DEF  = 256;
  localparam int MAX_POINTS_DEF = 64;

  localparam int TEMP_W = 8;
  localparam int PREC_W = 10;
  localparam int CLS_W  = 8;
  localparam int CELL_W = 8;
  localparam int R_W    = 9;            // signed temperature span
  localparam int XR_W   = 18;           // cell * span products
  localparam int DT_W   = 19;           // signed axis offsets
  localparam int MT_W   = DT_W + PREC_W + 1;
  localparam int MP_W   = DT_W + R_W;
  localparam int SQT_W  = 2 * MT_W;
  localparam int SQP_W  = 2 * MP_W;
  localparam int D_W    = 57;           // scaled squared distance

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RESULT
  } state_t;

  localparam logic [1:0] REG_MIN_TEMP   = 2'd0;
  localparam logic [1:0] REG_MAX_TEMP   = 2'd1;
  localparam logic [1:0] REG_MAX_PRECIP = 2'd2;

  typedef struct packed {
    logic [CLS_W-1:0]         cls;
    logic [PREC_W-1:0]        p;
    logic signed [TEMP_W-1:0] t;
  } point_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

  typedef struct packed {
    logic signed [XR_W-1:0]   xr;
    logic [XR_W-1:0]          yp;
    logic signed [TEMP_W-1:0] min_temp;
    logic signed [R_W-1:0]    r;
    logic [PREC_W-1:0]        pr;
  } query_t;

  typedef struct packed {
    tag_t             tag;
    logic [CLS_W-1:0] cls;
    logic [D_W-1:0]   d;
  } dist_t;

endpackage

>>> sv/nearest_point_classifier_2d_top.sv
// Each item is taken in the idle state and passes through execute, a point scan for a query
// over a non-empty store, and result; the next item is taken once the result is loaded.
// A scan feeds one point per cycle from the single read port of the point memory into the
// distance pipe.
// Reset: limits return to -30 / 50 / 500 and the point count to zero; memory is not cleared.
// Top level: item sequencer, point memory, configuration registers, result register.
module nearest_point_classifier_2d_top #(
  parameter int GRID_SIZE  = npc_pkg::GRID_SIZE_DEF,
  parameter int MAX_POINTS = npc_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // point_temp[7:0], point_precip[17:8], point_class[25:18], cell_x[33:26], cell_y[41:34]
  input  logic [47:0] s_tdata,
  // op[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // nearest_class[7:0], status[9:8]
  output logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [npc_pkg::CELL_W-1:0] G1 = npc_pkg::CELL_W'(GRID_SIZE - 1);

  // configuration
  logic signed [npc_pkg::TEMP_W-1:0] min_temp, max_temp;
  logic [npc_pkg::PREC_W-1:0]        max_precip;

  // sequencer and item
  npc_pkg::state_t             state, state_next;
  npc_pkg::op_t                it_op;
  npc_pkg::point_t             it_pt;
  logic [npc_pkg::CELL_W-1:0]  it_x, it_y, x_c, y_c;
  logic [CW-1:0]               count, issue_idx;
  logic                        issuing, out_of_range, full, out_load;
  logic signed [npc_pkg::R_W-1:0] r_c;

  // memory path
  npc_pkg::point_t mem [MAX_POINTS];
  npc_pkg::point_t rd_data;
  npc_pkg::tag_t   rd_tag;
  npc_pkg::query_t qry;
  npc_pkg::dist_t  dres;

  // result
  logic [npc_pkg::D_W-1:0]   best_d;
  logic [npc_pkg::CLS_W-1:0] res_cls;
  npc_pkg::status_t          res_status;

  assign pready   = 1'b1;
  assign s_tready = (state == npc_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_temp   <= -8'sd30;
      max_temp   <= 8'sd50;
      max_precip <= 10'd500;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        npc_pkg::REG_MIN_TEMP:   min_temp   <= $signed(pwdata[7:0]);
        npc_pkg::REG_MAX_TEMP:   max_temp   <= $signed(pwdata[7:0]);
        npc_pkg::REG_MAX_PRECIP: max_precip <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      npc_pkg::REG_MIN_TEMP:   prdata = {{24{min_temp[7]}}, min_temp};
      npc_pkg::REG_MAX_TEMP:   prdata = {{24{max_temp[7]}}, max_temp};
      npc_pkg::REG_MAX_PRECIP: prdata = {22'd0, max_precip};
      default:                 prdata = 32'd0;
    endcase
  end

  assign out_of_range = ($signed(it_pt.t) < min_temp) || ($signed(it_pt.t) >= max_temp)
                     || (it_pt.p >= max_precip);
  assign full     = (count == CW'(MAX_POINTS));
  assign x_c      = (it_x > G1) ? G1 : it_x;
  assign y_c      = (it_y > G1) ? G1 : it_y;
  assign r_c      = $signed({max_temp[7], max_temp}) - $signed({min_temp[7], min_temp});
  assign issuing  = (state == npc_pkg::S_SCAN) && (issue_idx < count);
  assign out_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      npc_pkg::S_IDLE: begin
        if (s_tvalid) state_next = npc_pkg::S_EXEC;
      end
      npc_pkg::S_EXEC: begin
        if (it_op == npc_pkg::OP_QUERY && count != '0) state_next = npc_pkg::S_SCAN;
        else state_next = npc_pkg::S_RESULT;
      end
      npc_pkg::S_SCAN: begin
        if (dres.tag.valid && dres.tag.last) state_next = npc_pkg::S_RESULT;
      end
      npc_pkg::S_RESULT: begin
        if (out_load) state_next = npc_pkg::S_IDLE;
      end
      default: state_next = npc_pkg::S_IDLE;
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      it_op     <= npc_pkg::op_t'(s_tuser[0]);
      it_pt.t   <= $signed(s_tdata[7:0]);
      it_pt.p   <= s_tdata[17:8];
      it_pt.cls <= s_tdata[25:18];
      it_x      <= s_tdata[33:26];
      it_y      <= s_tdata[41:34];
    end
  end

  // point memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == npc_pkg::S_EXEC && it_op == npc_pkg::OP_ADD && !out_of_range && !full) begin
      mem[count[AW-1:0]] <= it_pt;
    end
    rd_data <= mem[issue_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      issue_idx <= '0;
      rd_tag    <= '0;
    end else begin
      rd_tag.valid <= issuing;
      rd_tag.first <= (issue_idx == '0);
      rd_tag.last  <= (issue_idx == count - CW'(1));
      if (state == npc_pkg::S_EXEC) begin
        issue_idx <= '0;
        if (it_op == npc_pkg::OP_ADD && !out_of_range && !full) count <= count + CW'(1);
      end else if (issuing) begin
        issue_idx <= issue_idx + CW'(1);
      end
    end
  end

  // query constants and best-point tracking
  always_ff @(posedge clk) begin
    if (state == npc_pkg::S_EXEC) begin
      qry.xr       <= $signed({1'b0, x_c}) * r_c;
      qry.yp       <= y_c * max_precip;
      qry.r        <= r_c;
      qry.pr       <= max_precip;
      qry.min_temp <= min_temp;
      res_cls      <= '0;
      if (it_op == npc_pkg::OP_ADD) begin
        if (out_of_range)  res_status <= npc_pkg::ST_RANGE;
        else if (full)     res_status <= npc_pkg::ST_FULL;
        else               res_status <= npc_pkg::ST_OK;
      end else begin
        res_status <= (count == '0) ? npc_pkg::ST_EMPTY : npc_pkg::ST_OK;
      end
    end else if (dres.tag.valid && (dres.tag.first || dres.d < best_d)) begin
      // strict compare keeps the earliest point on ties
      best_d  <= dres.d;
      res_cls <= dres.cls;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == npc_pkg::S_RESULT && out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == npc_pkg::S_RESULT && out_load) begin
      m_tdata <= {6'd0, res_status, res_cls};
    end
  end

  npc_dist #(
    .GRID_SIZE(GRID_SIZE)
  ) u_dist (
    .clk   (clk),
    .rst   (rst),
    .in_tag(rd_tag),
    .in_pt (rd_data),
    .qry   (qry),
    .res   (dres)
  );

endmodule

>>> sv/npc_dist.sv
// Three-stage distance pipeline: axis offsets, scaling, squares and sum.
module npc_dist #(
  parameter int GRID_SIZE = npc_pkg::GRID_SIZE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  npc_pkg::tag_t   in_tag,
  input  npc_pkg::point_t in_pt,
  input  npc_pkg::query_t qry,
  output npc_pkg::dist_t  res
);

  localparam logic [7:0]        G1  = 8'(GRID_SIZE - 1);
  localparam logic signed [8:0] G1S = $signed({1'b0, G1});

  // stage 1
  logic signed [npc_pkg::R_W-1:0]  toff;
  logic signed [npc_pkg::XR_W-1:0] tg;
  logic [npc_pkg::XR_W-1:0]        pg;
  logic signed [npc_pkg::DT_W-1:0] dt1, dp1;
  npc_pkg::tag_t                   tag1;
  logic [npc_pkg::CLS_W-1:0]       cls1;

  // stage 2
  logic signed [npc_pkg::MT_W-1:0] mt2;
  logic signed [npc_pkg::MP_W-1:0] mp2;
  npc_pkg::tag_t                   tag2;
  logic [npc_pkg::CLS_W-1:0]       cls2;

  // stage 3
  logic signed [npc_pkg::SQT_W-1:0] st_full;
  logic signed [npc_pkg::SQP_W-1:0] sp_full;
  logic [npc_pkg::D_W-1:0]          sqt3, sqp3;
  npc_pkg::tag_t                    tag3;
  logic [npc_pkg::CLS_W-1:0]        cls3;

  assign toff = $signed({in_pt.t[npc_pkg::TEMP_W-1], in_pt.t})
              - $signed({qry.min_temp[npc_pkg::TEMP_W-1], qry.min_temp});
  assign tg = toff * G1S;
  assign pg = in_pt.p * G1;

  assign st_full = mt2 * mt2;
  assign sp_full = mp2 * mp2;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
    end else begin
      tag1 <= in_tag;
      tag2 <= tag1;
      tag3 <= tag2;
    end
  end

  always_ff @(posedge clk) begin
    dt1  <= $signed({qry.xr[npc_pkg::XR_W-1], qry.xr}) - $signed({tg[npc_pkg::XR_W-1], tg});
    dp1  <= $signed({1'b0, qry.yp}) - $signed({1'b0, pg});
    cls1 <= in_pt.cls;

    mt2  <= dt1 * $signed({1'b0, qry.pr});
    mp2  <= dp1 * $signed(qry.r);
    cls2 <= cls1;

    // squares stay below 2^55, the low bits carry the whole value
    sqt3 <= st_full[npc_pkg::D_W-1:0];
    sqp3 <= sp_full[npc_pkg::D_W-1:0];
    cls3 <= cls2;
  end

  assign res.tag = tag3;
  assign res.cls = cls3;
  assign res.d   = sqt3 + sqp3;

endmodule

>>> sv/npc_checker.sv
// Port-level checks for the nearest point classifier, bound to the top level.
module npc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // one item at a time: intake closes once a word is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

  // failed adds and queries carry class zero
  a_class_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9:8] != npc_pkg::ST_OK) |-> (m_tdata[7:0] == 8'd0))
    else $error("nonzero class with error status");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result word changed");

endmodule

bind nearest_point_classifier_2d_top npc_checker u_npc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the classifier: table-driven and random words against a predictor.
module tb;

  localparam int GRID       = npc_pkg::GRID_SIZE_DEF;
  localparam int STORE_CAP  = npc_pkg::MAX_POINTS_DEF;
  localparam int IDLE_LIMIT = 1000;
  localparam int N_PHASES   = 8;
  localparam int N_ROWS     = 21;

  typedef struct {
    logic [npc_pkg::CLS_W-1:0] cls;
    npc_pkg::status_t          status;
  } answer_t;

  typedef struct {
    npc_pkg::op_t     op;
    int               t, p, c, x, y;
    bit               typed;
    int               cls;
    npc_pkg::status_t status;
  } stim_row_t;

  typedef struct {
    int min_t, max_t, prec, items, add_pct;
  } limits_t;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  int         lim_min  = -30;
  int         lim_max  = 50;
  int         lim_prec = 500;
  int         pt_temp [STORE_CAP];
  int         pt_prec [STORE_CAP];
  logic [7:0] pt_cls  [STORE_CAP];
  int         n_points = 0;
  answer_t    answers_due [$];

  int n_stored   = 0;
  int n_rejected = 0;
  int n_full     = 0;
  int n_empty    = 0;
  int n_queries  = 0;
  int n_errors   = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  // reset limits are -30 / 50 / 500; first rows hit the empty store and every range edge
  stim_row_t directed_rows [N_ROWS] = '{
    '{npc_pkg::OP_QUERY,    0,    0,   0,   0,   0, 1'b1,   0, npc_pkg::ST_EMPTY},
    '{npc_pkg::OP_QUERY,    0,    0,   0, 255, 255, 1'b1,   0, npc_pkg::ST_EMPTY},
    '{npc_pkg::OP_ADD,   -128,    0,   1,   0,   0, 1'b1,   0, npc_pkg::ST_RANGE},
    '{npc_pkg::OP_ADD,    127,    0,   2,   0,   0, 1'b1,   0, npc_pkg::ST_RANGE},
    '{npc_pkg::OP_ADD,     50,   10,   3,   0,   0, 1'b1,   0, npc_pkg::ST_RANGE},
    '{npc_pkg::OP_ADD,    -31,   10,   4,   0,   0, 1'b1,   0, npc_pkg::ST_RANGE},
    '{npc_pkg::OP_ADD,      0,  500,   5,   0,   0, 1'b1,   0, npc_pkg::ST_RANGE},
    '{npc_pkg::OP_ADD,      0, 1023,   6,   0,   0, 1'b1,   0, npc_pkg::ST_RANGE},
    '{npc_pkg::OP_ADD,    -30,    0, 170,   0,   0, 1'b1,   0, npc_pkg::ST_OK},
    '{npc_pkg::OP_QUERY,    0,    0,   0,   0,   0, 1'b1, 170, npc_pkg::ST_OK},
    '{npc_pkg::OP_QUERY,    0,    0,   0, 255, 255, 1'b1, 170, npc_pkg::ST_OK},
    '{npc_pkg::OP_ADD,     49,  499,  85,   0,   0, 1'b1,   0, npc_pkg::ST_OK},
    '{npc_pkg::OP_QUERY,    0,    0,   0, 255, 255, 1'b0,   0, npc_pkg::ST_OK},
    '{npc_pkg::OP_ADD,    -30,    0, 255,   0,   0, 1'b1,   0, npc_pkg::ST_OK},
    '{npc_pkg::OP_QUERY,    0,    0,   0,   0,   0, 1'b0,   0, npc_pkg::ST_OK},
    '{npc_pkg::OP_ADD,     10,  250,   0,   0,   0, 1'b1,   0, npc_pkg::ST_OK},
    '{npc_pkg::OP_QUERY,    0,    0,   0, 128, 128, 1'b0,   0, npc_pkg::ST_OK},
    '{npc_pkg::OP_QUERY,    0,    0,   0,  77,   3, 1'b0,   0, npc_pkg::ST_OK},
    '{npc_pkg::OP_ADD,     -1,    1, 128,   0,   0, 1'b1,   0, npc_pkg::ST_OK},
    '{npc_pkg::OP_QUERY,    0,    0,   0,   0, 255, 1'b0,   0, npc_pkg::ST_OK},
    '{npc_pkg::OP_QUERY,    0,    0,   0, 255,   0, 1'b0,   0, npc_pkg::ST_OK}
  };

  // wide extremes, single-cell range, inverted span with zero precip, zero span, then mixed
  limits_t phases [N_PHASES] = '{
    '{-128, 127, 1023, 300, 20},
    '{   0,   1,    1, 160, 40},
    '{  20, -20,    0, 160, 30},
    '{   5,   5, 1023, 160, 30},
    '{ -50,  90,  700, 250, 30},
    '{ -10,  10,   64, 250, 30},
    '{ 100, 127,    2, 200, 30},
    '{ -30,  50,  500, 350, 30}
  };

  nearest_point_classifier_2d_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one item to the predicted store and returns the answer word it should produce.
  // Distance is the cross-multiplied integer form, so no division is needed.
  function automatic answer_t answer_for(npc_pkg::op_t op, int t, int p, int c, int x, int y);
    answer_t a;
    longint  r, pr, dt, dp, d, best, cx, cy;
    int      i;
    a.cls    = '0;
    a.status = npc_pkg::ST_OK;
    if (op == npc_pkg::OP_ADD) begin
      if (t < lim_min || t >= lim_max || p >= lim_prec) begin
        a.status = npc_pkg::ST_RANGE;
        n_rejected++;
      end else if (n_points >= STORE_CAP) begin
        a.status = npc_pkg::ST_FULL;
        n_full++;
      end else begin
        pt_temp[n_points] = t;
        pt_prec[n_points] = p;
        pt_cls[n_points]  = c[7:0];
        n_points++;
        n_stored++;
      end
    end else if (n_points == 0) begin
      a.status = npc_pkg::ST_EMPTY;
      n_empty++;
    end else begin
      n_queries++;
      cx   = (x > GRID - 1) ? GRID - 1 : x;
      cy   = (y > GRID - 1) ? GRID - 1 : y;
      r    = lim_max - lim_min;
      pr   = lim_prec;
      best = 0;
      for (i = 0; i < n_points; i++) begin
        dt = cx * r - (longint'(pt_temp[i]) - lim_min) * (GRID - 1);
        dp = cy * pr - longint'(pt_prec[i]) * (GRID - 1);
        d  = (dt * dt) * (pr * pr) + (dp * dp) * (r * r);
        // strict compare: earliest point keeps a tie
        if (i == 0 || d < best) begin
          best  = d;
          a.cls = pt_cls[i];
        end
      end
    end
    return a;
  endfunction

  task automatic send_item(npc_pkg::op_t op, int t, int p, int c, int x, int y, bit typed,
                           answer_t typed_ans);
    answer_t a;
    if (!quiet && $urandom_range(5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    s_tuser  <= op;
    s_tdata  <= {6'd0, 8'(y), 8'(x), 8'(c), 10'(p), 8'(t)};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    a = answer_for(op, t, p, c, x, y);
    answers_due.insert(answers_due.size(), typed ? typed_ans : a);
  endtask

  // Leaves psel/penable high; the caller drops them after the last write.
  task automatic write_limit(logic [1:0] idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      npc_pkg::REG_MIN_TEMP:   lim_min  = $signed(value[7:0]);
      npc_pkg::REG_MAX_TEMP:   lim_max  = $signed(value[7:0]);
      npc_pkg::REG_MAX_PRECIP: lim_prec = value & 'h3FF;
      default: ;
    endcase
  endtask

  task automatic set_limits(limits_t lim);
    write_limit(npc_pkg::REG_MIN_TEMP, lim.min_t);
    write_limit(npc_pkg::REG_MAX_TEMP, lim.max_t);
    write_limit(npc_pkg::REG_MAX_PRECIP, lim.prec);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(7, 1)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (answers_due.size() == 0) begin
        $error("result word with nothing outstanding: class %0d status %0d",
               m_tdata[7:0], m_tdata[9:8]);
        n_errors++;
      end else begin
        want = answers_due[0];
        answers_due.delete(0);
        if (m_tdata[7:0] !== want.cls) begin
          $error("nearest_class: expected %0d, got %0d", want.cls, m_tdata[7:0]);
          n_errors++;
        end
        if (m_tdata[9:8] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[9:8]);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    answer_t      typed_ans;
    limits_t      lim;
    npc_pkg::op_t op;
    int           t, p, x, y;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      typed_ans.cls    = directed_rows[k].cls[7:0];
      typed_ans.status = directed_rows[k].status;
      send_item(directed_rows[k].op, directed_rows[k].t, directed_rows[k].p,
                directed_rows[k].c, directed_rows[k].x, directed_rows[k].y,
                directed_rows[k].typed, typed_ans);
    end

    foreach (phases[k]) begin
      lim = phases[k];
      s_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clk);
      quiet = (k == N_PHASES - 1);
      set_limits(lim);
      repeat (lim.items) begin
        op = ($urandom_range(99) < lim.add_pct) ? npc_pkg::OP_ADD : npc_pkg::OP_QUERY;
        t  = int'($urandom_range(255)) - 128;
        p  = $urandom_range(1023);
        // mostly legal adds so the store fills and ties build up
        if (op == npc_pkg::OP_ADD && lim_max > lim_min && lim_prec > 0
            && $urandom_range(9) < 8) begin
          t = lim_min + $urandom_range(lim_max - lim_min - 1);
          p = $urandom_range(lim_prec - 1);
        end
        x = ($urandom_range(7) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
        y = ($urandom_range(7) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
        send_item(op, t, p, $urandom_range(255), x, y, 1'b0, typed_ans);
      end
    end

    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d stored points, %0d out-of-range adds, %0d adds to a full store,",
             n_stored, n_rejected, n_full);
    $display("%0d empty-store queries and %0d nearest-point queries under %0d limit sets",
             n_empty, n_queries, N_PHASES + 1);
    if (n_errors == 0 && answers_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
